// File: hdl/lni_pkg.sv
// Shared constants, codes and types for the line number inserter.
`default_nettype none

package lni_pkg;

    localparam int NUMBER_BUFFER = 20;
    localparam int MIN_WIDTH     = 6;
    localparam int DIGIT_CAP     = NUMBER_BUFFER - 2;
    localparam int MIN_W_CAP     = (MIN_WIDTH > DIGIT_CAP) ? DIGIT_CAP : MIN_WIDTH;
    localparam int IDX_W         = $clog2(DIGIT_CAP);
    localparam int CNT_W         = $clog2(DIGIT_CAP + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    localparam logic [3:0] DIGIT_NINE = 4'd9;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_NONBLANK = 2'd2;

    typedef logic [3:0] digit_t;

    // command from the sequencer to the digit ring
    typedef struct packed {
        logic             inc;     // increment step, ring rotates towards slot 0
        logic             rot_up;  // display step, ring rotates towards the top slot
        logic [IDX_W-1:0] step;    // ring position handled this cycle
    } ring_cmd_t;

    // ring status back to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] digit_count;
        logic             overflow;
        digit_t           top_digit;
    } ring_stat_t;

endpackage

`default_nettype wire

// File: hdl/line_number_inserter.sv
// Top level of the line number inserter: mode register, sequencer and digit ring.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid/s_ready    s_data_byte[7:0]
//   m_*          out  m_valid/m_ready    m_out_byte[7:0], m_last_of_run
//   cfg_*        in   cfg_wr_en          cfg_wr_data[1:0] (number mode)
//
// Plain text that gets no prefix streams at one word per cycle while the output is not stalled.
// For a numbered line start the word is accepted, then one pass round the digit ring increments,
// one pass displays, then the tab and the input word go out; no new word is taken meanwhile.
// Output back-pressure stalls the sequencer only on cycles that emit or accept a word.
// Reset is synchronous, active low: counter 1 digit of zero, mode off, at line start.
`default_nettype none

module line_number_inserter import lni_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    logic [1:0] number_mode_reg, number_mode_next;
    ring_cmd_t  cmd;
    ring_stat_t stat;

    assign number_mode_next = cfg_wr_en ? cfg_wr_data : number_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_mode_reg <= MODE_NONE;
        end else begin
            number_mode_reg <= number_mode_next;
        end
    end

    lni_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .number_mode   (number_mode_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .stat          (stat)
    );

    lni_counter u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire

// File: hdl/lni_counter.sv
// Decimal line counter held as a rotating ring of BCD digits, one digit per cycle.
`default_nettype none

module lni_counter import lni_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ring_cmd_t  cmd,
    output ring_stat_t      stat
);

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DIGIT_CAP - 1);

    digit_t           ring_reg  [DIGIT_CAP];
    digit_t           ring_next [DIGIT_CAP];
    logic [CNT_W-1:0] dc_reg, dc_next;
    logic             ovf_reg, ovf_next;
    logic             carry_reg, carry_next;

    logic             carry_in;
    digit_t           low_digit;
    digit_t           new_digit;
    logic             carry_out;
    logic [CNT_W-1:0] step_ext;

    always_comb begin
        step_ext  = CNT_W'(cmd.step);
        low_digit = ring_reg[0];
        carry_in  = (cmd.step == '0) ? 1'b1 : carry_reg;
        new_digit = low_digit;
        carry_out = carry_in;
        dc_next   = dc_reg;
        ovf_next  = ovf_reg;

        if (step_ext < dc_reg) begin
            if (carry_in) begin
                if (low_digit < DIGIT_NINE) begin
                    new_digit = low_digit + 4'd1;
                    carry_out = 1'b0;
                end else begin
                    new_digit = '0;
                    carry_out = 1'b1;
                end
            end
        end else if (step_ext == dc_reg && carry_in) begin
            // counter grows by one digit
            new_digit = 4'd1;
            carry_out = 1'b0;
            if (cmd.inc) begin
                dc_next = dc_reg + CNT_W'(1);
            end
        end

        if (cmd.inc && cmd.step == LAST_STEP && carry_out) begin
            ovf_next = 1'b1;
        end
        carry_next = cmd.inc ? carry_out : carry_reg;

        for (int j = 0; j < DIGIT_CAP; j++) begin
            ring_next[j] = ring_reg[j];
        end
        if (cmd.inc) begin
            for (int j = 0; j < DIGIT_CAP - 1; j++) begin
                ring_next[j] = ring_reg[j + 1];
            end
            ring_next[DIGIT_CAP - 1] = new_digit;
        end else if (cmd.rot_up) begin
            for (int j = 1; j < DIGIT_CAP; j++) begin
                ring_next[j] = ring_reg[j - 1];
            end
            ring_next[0] = ring_reg[DIGIT_CAP - 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DIGIT_CAP; j++) begin
                ring_reg[j] <= '0;
            end
            dc_reg    <= CNT_W'(1);
            ovf_reg   <= 1'b0;
            carry_reg <= 1'b0;
        end else begin
            for (int j = 0; j < DIGIT_CAP; j++) begin
                ring_reg[j] <= ring_next[j];
            end
            dc_reg    <= dc_next;
            ovf_reg   <= ovf_next;
            carry_reg <= carry_next;
        end
    end

    assign stat.digit_count = dc_reg;
    assign stat.overflow    = ovf_reg;
    assign stat.top_digit   = ring_reg[DIGIT_CAP - 1];

endmodule

`default_nettype wire

// File: hdl/lni_ctrl.sv
// Sequencer: input word capture, prefix generation and output register.
`default_nettype none

module lni_ctrl import lni_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] number_mode,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run,
    output ring_cmd_t       cmd,
    input  wire ring_stat_t stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INC  = 3'd1;
    localparam logic [2:0] S_PFX  = 3'd2;
    localparam logic [2:0] S_TAB  = 3'd3;
    localparam logic [2:0] S_BYTE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DIGIT_CAP - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [7:0]       byte_reg, byte_next;
    logic             line_start_reg, line_start_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;

    logic             slot_free;
    logic             accept;
    logic             is_nl;
    logic             number_it;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] pos_ext;
    logic             pos_digit;
    logic             pfx_emit;
    logic [7:0]       pfx_char;
    logic             load;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign is_nl     = (s_data_byte == CHAR_NL);
    assign number_it = line_start_reg &&
                       (number_mode == MODE_ALL ||
                        (number_mode == MODE_NONBLANK && !is_nl));

    // display pass walks from the top ring position down to zero
    assign pos       = LAST_STEP - step_reg;
    assign pos_ext   = CNT_W'(pos);
    assign pos_digit = pos_ext < stat.digit_count;
    assign pfx_emit  = pos_digit || (pos_ext < CNT_W'(MIN_W_CAP));

    always_comb begin
        if (!pos_digit) begin
            pfx_char = CHAR_SPACE;
        end else if (stat.overflow && pos == LAST_STEP) begin
            pfx_char = CHAR_GT;
        end else begin
            pfx_char = CHAR_ZERO + {4'b0000, stat.top_digit};
        end
    end

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        byte_next       = byte_reg;
        line_start_next = line_start_reg;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        load            = 1'b0;
        cmd.inc         = 1'b0;
        cmd.rot_up      = 1'b0;
        cmd.step        = step_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    line_start_next = is_nl;
                    if (number_it) begin
                        byte_next  = s_data_byte;
                        step_next  = '0;
                        state_next = S_INC;
                    end else begin
                        load        = 1'b1;
                        m_byte_next = s_data_byte;
                        m_last_next = 1'b1;
                    end
                end
            end
            S_INC: begin
                cmd.inc = 1'b1;
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    state_next = S_PFX;
                end else begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_PFX: begin
                if (!pfx_emit || slot_free) begin
                    cmd.rot_up = 1'b1;
                    if (pfx_emit) begin
                        load        = 1'b1;
                        m_byte_next = pfx_char;
                        m_last_next = 1'b0;
                    end
                    if (step_reg == LAST_STEP) begin
                        step_next  = '0;
                        state_next = S_TAB;
                    end else begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            S_TAB: begin
                if (slot_free) begin
                    load        = 1'b1;
                    m_byte_next = CHAR_TAB;
                    m_last_next = 1'b0;
                    state_next  = S_BYTE;
                end
            end
            S_BYTE: begin
                if (slot_free) begin
                    load        = 1'b1;
                    m_byte_next = byte_reg;
                    m_last_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            line_start_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            line_start_reg <= line_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;

endmodule

`default_nettype wire

// File: tb/tb_line_number_inserter.sv
// Testbench for the line number inserter: directed and random text against a prefix predictor.
`timescale 1ns / 100ps

module tb_line_number_inserter import lni_pkg::*;;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS = 25;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_word_t;

    class numbered_text;
        logic [1:0]  mode;
        bit          at_start;
        digit_t      digits [DIGIT_CAP];
        int unsigned ndigits;
        bit          wrapped;
        out_word_t   due_words [$];
        int unsigned mismatches;

        function new();
            mode = MODE_NONE;
            at_start = 1'b1;
            foreach (digits[i]) digits[i] = '0;
            ndigits = 1;
            wrapped = 1'b0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return due_words.size();
        endfunction

        function void queue_word(logic [7:0] ch, logic last);
            out_word_t w;
            w.ch = ch;
            w.last = last;
            due_words.push_back(w);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void take_text_word(logic [7:0] b);
            bit          is_nl;
            bit          numbered;
            bit          carry;
            int unsigned i;
            int unsigned width;
            is_nl = (b == CHAR_NL);
            numbered = at_start && (mode == MODE_ALL || (mode == MODE_NONBLANK && !is_nl));
            if (numbered) begin
                carry = 1'b1;
                if (ndigits < 1 || ndigits > DIGIT_CAP) ndigits = 1;
                for (i = 0; i < ndigits && carry; i++) begin
                    if (digits[i] < DIGIT_NINE) begin
                        digits[i] = digits[i] + 4'd1;
                        carry = 1'b0;
                    end else begin
                        digits[i] = '0;
                    end
                end
                if (carry) begin
                    if (ndigits < DIGIT_CAP) begin
                        digits[ndigits] = 4'd1;
                        ndigits++;
                    end else begin
                        wrapped = 1'b1;
                    end
                end
                width = (ndigits > MIN_WIDTH) ? ndigits : MIN_WIDTH;
                if (width > DIGIT_CAP) width = DIGIT_CAP;
                for (i = ndigits; i < width; i++) queue_word(CHAR_SPACE, 1'b0);
                for (i = ndigits; i > 0; i--) begin
                    if (wrapped && i == DIGIT_CAP)
                        queue_word(CHAR_GT, 1'b0);
                    else
                        queue_word(CHAR_ZERO + {4'd0, digits[i-1]}, 1'b0);
                end
                queue_word(CHAR_TAB, 1'b0);
            end
            queue_word(b, 1'b1);
            at_start = is_nl;
        endfunction

        task match_out_word(logic [7:0] ch, logic last);
            out_word_t w;
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h last %0b", ch, last));
            end else begin
                w = due_words.pop_front();
                if (ch !== w.ch)
                    report_mismatch($sformatf("out_byte %02h, want %02h", ch, w.ch));
                if (last !== w.last)
                    report_mismatch($sformatf("last_of_run %0b, want %0b", last, w.last));
            end
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = MODE_NONE;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    numbered_text tracker;
    bit steady = 1'b0;

    line_number_inserter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] text_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return CHAR_NL;
        if (r < 40) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // input and output words are both taken from pre-edge values
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) tracker.take_text_word(s_data_byte);
            if (m_valid === 1'b1 && m_ready) tracker.match_out_word(m_out_byte, m_last_of_run);
        end
    end

    initial begin
        int g;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            g = pick_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [7:0] b);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (tracker.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.mode = m;
    endtask

    initial begin
        logic [1:0] phase_mode [RANDOM_PHASES];
        phase_mode = '{MODE_ALL, MODE_NONBLANK, MODE_NONE, MODE_ALL,
                       MODE_SPARE, MODE_NONBLANK, MODE_ALL, MODE_NONE};
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mode left at its reset value
        send_word(8'h00); send_word(8'hFF); send_word(CHAR_NL);
        drain();
        set_mode(MODE_ALL);
        send_word(CHAR_NL); send_word(CHAR_NL); send_word(8'h61);
        send_word(8'h55); send_word(CHAR_NL);
        drain();
        set_mode(MODE_NONBLANK);
        send_word(CHAR_NL); send_word(CHAR_NL); send_word(8'hAA);
        send_word(CHAR_NL); send_word(8'h7F);
        // change of mode part way through a line
        drain();
        set_mode(MODE_ALL);
        send_word(8'h41); send_word(CHAR_NL);
        drain();
        set_mode(MODE_SPARE);
        send_word(8'h30); send_word(CHAR_NL); send_word(CHAR_NL);
        drain();
        set_mode(MODE_NONE);
        send_word(CHAR_NL); send_word(CHAR_TAB);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            set_mode(phase_mode[p]);
            steady = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2 && (p == 0 || $urandom_range(0, 1))) drain();
                send_word(text_word());
            end
        end
        steady = 1'b0;
        drain();

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("** line_number_inserter: PASSED **");
        else
            $display("** line_number_inserter: FAILED **");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("** line_number_inserter: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lni_pkg.sv
hdl/lni_counter.sv
hdl/lni_ctrl.sv
hdl/line_number_inserter.sv
tb/tb_line_number_inserter.sv
